>>> rtl/tce_pkg.sv
// Shared constants, types and tables of the text console engine.
package tce_pkg;

  localparam int ROWS      = 25;
  localparam int COLS      = 80;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = ROWS * COLS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int TAB_W  = $clog2(TAB_WIDTH + 1);

  // Port field widths
  localparam int CMD_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int XCOL_W   = 7;
  localparam int YROW_W   = 5;
  localparam int HW_W     = 11;
  localparam int SCROLL_W = 16;
  localparam int CELL_W   = 16;
  localparam int NIB_W    = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;
  localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

  localparam logic [NIB_W-1:0] FG_RESET = 4'h7;
  localparam logic [NIB_W-1:0] BG_RESET = 4'h0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT       = 3'd0,
    CMD_GOTO      = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_CLEAR_EOL = 3'd3,
    CMD_CLEAR_EOS = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG        = 2'd0,
    CFG_BG        = 2'd1,
    CFG_RAW       = 2'd2,
    CFG_CURSOR_EN = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [XCOL_W-1:0] x;
    logic [YROW_W-1:0] y;
  } cmd_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]   cell_val;
    logic [SCROLL_W-1:0] scroll;
    logic [HW_W-1:0]     offset;
    logic [YROW_W-1:0]   line;
    logic [XCOL_W-1:0]   col;
  } result_t;

  // Spaces a tab emits from each column
  typedef logic [TAB_W-1:0] tab_lut_t [COLS];

  function automatic tab_lut_t build_tab_lut();
    tab_lut_t lut;
    for (int i = 0; i < COLS; i++) begin
      lut[i] = TAB_W'(TAB_WIDTH - (i % TAB_WIDTH));
    end
    return lut;
  endfunction

  localparam tab_lut_t TAB_LUT = build_tab_lut();

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(32'(r) * COLS + 32'(c));
  endfunction

endpackage

>>> rtl/tce_ram.sv
// Generic simple dual-port RAM with registered read.
module tce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/tce_core.sv
// Command sequencer: cursor state, scroll and fill sweeps over the screen memory.
module tce_core (
  input  logic                clk,
  input  logic                rst,
  input  tce_pkg::cfg_wr_t    cfg,
  input  logic                item_valid,
  input  tce_pkg::cmd_item_t  item,
  output logic                item_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output tce_pkg::result_t    res
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_WRITE     = 9'b000000010,
    S_COPY      = 9'b000000100,
    S_DRAIN     = 9'b000001000,
    S_FILL      = 9'b000010000,
    S_READ      = 9'b000100000,
    S_READ_WAIT = 9'b001000000,
    S_FINISH    = 9'b010000000,
    S_RESULT    = 9'b100000000
  } state_t;

  state_t state;

  logic [tce_pkg::COL_W-1:0]    col;
  logic [tce_pkg::ROW_W-1:0]    row;
  logic [tce_pkg::SCROLL_W-1:0] scroll;
  logic [tce_pkg::HW_W-1:0]     hw;
  logic [tce_pkg::CELL_W-1:0]   rd_cell;
  logic [tce_pkg::TAB_W-1:0]    tab_left;
  logic [tce_pkg::CHAR_W-1:0]   wch;
  logic                         sync_pend;
  logic                         init_clear;
  logic [tce_pkg::ADDR_W-1:0]   fill_ptr;
  logic [tce_pkg::ADDR_W-1:0]   fill_end;
  logic [tce_pkg::ADDR_W-1:0]   cp_ptr;
  logic [tce_pkg::ADDR_W-1:0]   cp_waddr;
  logic                         cp_valid;
  logic [tce_pkg::ADDR_W-1:0]   rd_addr;
  logic [tce_pkg::NIB_W-1:0]    fg;
  logic [tce_pkg::NIB_W-1:0]    bg;
  logic                         raw;
  logic                         cen;

  logic                         ram_we;
  logic [tce_pkg::ADDR_W-1:0]   ram_waddr;
  logic [tce_pkg::CELL_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [tce_pkg::ADDR_W-1:0]   ram_raddr;
  logic [tce_pkg::CELL_W-1:0]   ram_rdata;

  logic [tce_pkg::ADDR_W-1:0]   cur_addr;
  logic                         at_bottom;
  logic                         in_range;
  logic                         is_write;

  tce_ram #(
    .WIDTH (tce_pkg::CELL_W),
    .DEPTH (tce_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_addr  = tce_pkg::cell_addr(row, col);
  assign at_bottom = (row >= tce_pkg::ROW_W'(tce_pkg::ROWS - 1));
  assign in_range  = (32'(item.x) < tce_pkg::COLS) && (32'(item.y) < tce_pkg::ROWS);
  assign is_write  = raw || !((item.ch == tce_pkg::CODE_TAB) || (item.ch == tce_pkg::CODE_CR) ||
                              (item.ch == tce_pkg::CODE_LF) || (item.ch == tce_pkg::CODE_BS));

  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_RESULT);

  assign res.col      = tce_pkg::XCOL_W'(col);
  assign res.line     = tce_pkg::YROW_W'(row);
  assign res.offset   = hw;
  assign res.scroll   = scroll;
  assign res.cell_val = rd_cell;

  // Copy beats of a scroll take the write port ahead of everything else
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_ptr;
    ram_wdata = tce_pkg::BLANK_CELL;
    ram_re    = 1'b0;
    ram_raddr = cp_ptr;
    if (cp_valid) begin
      ram_we    = 1'b1;
      ram_waddr = cp_waddr;
      ram_wdata = ram_rdata;
    end else begin
      case (state)
        S_FILL: begin
          ram_we = 1'b1;
        end
        S_WRITE: begin
          ram_we    = 1'b1;
          ram_waddr = cur_addr;
          ram_wdata = {bg, fg, wch};
        end
        default: ;
      endcase
    end
    case (state)
      S_COPY: begin
        ram_re = 1'b1;
      end
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = rd_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      fill_ptr   <= '0;
      fill_end   <= tce_pkg::ADDR_W'(tce_pkg::CELLS - 1);
      init_clear <= 1'b1;
      cp_valid   <= 1'b0;
      tab_left   <= '0;
      sync_pend  <= 1'b0;
      col        <= '0;
      row        <= '0;
      scroll     <= '0;
      hw         <= '0;
      rd_cell    <= '0;
      fg         <= tce_pkg::FG_RESET;
      bg         <= tce_pkg::BG_RESET;
      raw        <= 1'b0;
      cen        <= 1'b1;
    end else begin
      cp_valid <= 1'b0;

      if (cfg.en) begin
        case (cfg.index)
          tce_pkg::CFG_FG:  fg  <= cfg.data;
          tce_pkg::CFG_BG:  bg  <= cfg.data;
          tce_pkg::CFG_RAW: raw <= cfg.data[0];
          tce_pkg::CFG_CURSOR_EN: begin
            cen <= cfg.data[0];
            if (cfg.data[0]) begin
              hw <= tce_pkg::HW_W'(cur_addr);
            end
          end
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            rd_cell   <= '0;
            sync_pend <= 1'b0;
            tab_left  <= '0;
            state     <= S_FINISH;
            case (item.cmd)
              tce_pkg::CMD_PUT: begin
                if (is_write) begin
                  wch      <= item.ch;
                  tab_left <= tce_pkg::TAB_W'(1);
                  state    <= S_WRITE;
                end else begin
                  sync_pend <= 1'b1;
                  case (item.ch)
                    tce_pkg::CODE_TAB: begin
                      wch      <= tce_pkg::CODE_SPACE;
                      tab_left <= tce_pkg::TAB_LUT[col];
                      state    <= S_WRITE;
                    end
                    tce_pkg::CODE_CR: begin
                      col <= '0;
                    end
                    tce_pkg::CODE_LF: begin
                      if (at_bottom) begin
                        cp_ptr <= tce_pkg::ADDR_W'(tce_pkg::COLS);
                        state  <= S_COPY;
                      end else begin
                        row <= row + 1'b1;
                      end
                    end
                    default: begin
                      // backspace: never erases, holds at the top left corner
                      if (col != '0) begin
                        col <= col - 1'b1;
                      end else if (row != '0) begin
                        row <= row - 1'b1;
                        col <= tce_pkg::COL_W'(tce_pkg::COLS - 1);
                      end
                    end
                  endcase
                end
              end
              tce_pkg::CMD_GOTO: begin
                if (in_range) begin
                  col       <= tce_pkg::COL_W'(item.x);
                  row       <= tce_pkg::ROW_W'(item.y);
                  sync_pend <= 1'b1;
                end
              end
              tce_pkg::CMD_CLEAR: begin
                fill_ptr  <= '0;
                fill_end  <= tce_pkg::ADDR_W'(tce_pkg::CELLS - 1);
                col       <= '0;
                row       <= '0;
                sync_pend <= 1'b1;
                state     <= S_FILL;
              end
              tce_pkg::CMD_CLEAR_EOL: begin
                fill_ptr <= cur_addr;
                fill_end <= tce_pkg::cell_addr(row, tce_pkg::COL_W'(tce_pkg::COLS - 1));
                state    <= S_FILL;
              end
              tce_pkg::CMD_CLEAR_EOS: begin
                fill_ptr <= cur_addr;
                fill_end <= tce_pkg::ADDR_W'(tce_pkg::CELLS - 1);
                state    <= S_FILL;
              end
              tce_pkg::CMD_READ: begin
                if (in_range) begin
                  rd_addr <= tce_pkg::cell_addr(tce_pkg::ROW_W'(item.y),
                                                tce_pkg::COL_W'(item.x));
                  state   <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end

        S_WRITE: begin
          sync_pend <= 1'b1;
          tab_left  <= tab_left - 1'b1;
          if (col == tce_pkg::COL_W'(tce_pkg::COLS - 1)) begin
            col <= '0;
            if (at_bottom) begin
              cp_ptr <= tce_pkg::ADDR_W'(tce_pkg::COLS);
              state  <= S_COPY;
            end else begin
              row   <= row + 1'b1;
              state <= (tab_left > tce_pkg::TAB_W'(1)) ? S_WRITE : S_FINISH;
            end
          end else begin
            col   <= col + 1'b1;
            state <= (tab_left > tce_pkg::TAB_W'(1)) ? S_WRITE : S_FINISH;
          end
        end

        // Read one row below, write it back one row up on the next beat
        S_COPY: begin
          cp_valid <= 1'b1;
          cp_waddr <= cp_ptr - tce_pkg::ADDR_W'(tce_pkg::COLS);
          if (cp_ptr == tce_pkg::ADDR_W'(tce_pkg::CELLS - 1)) begin
            state <= S_DRAIN;
          end else begin
            cp_ptr <= cp_ptr + 1'b1;
          end
        end

        S_DRAIN: begin
          scroll   <= scroll + 1'b1;
          fill_ptr <= tce_pkg::ADDR_W'(tce_pkg::CELLS - tce_pkg::COLS);
          fill_end <= tce_pkg::ADDR_W'(tce_pkg::CELLS - 1);
          state    <= S_FILL;
        end

        S_FILL: begin
          fill_ptr <= fill_ptr + 1'b1;
          if (fill_ptr == fill_end) begin
            init_clear <= 1'b0;
            if (init_clear) begin
              state <= S_IDLE;
            end else begin
              state <= (tab_left != '0) ? S_WRITE : S_FINISH;
            end
          end
        end

        S_READ: begin
          state <= S_READ_WAIT;
        end

        S_READ_WAIT: begin
          rd_cell <= ram_rdata;
          state   <= S_FINISH;
        end

        S_FINISH: begin
          if (sync_pend && cen) begin
            hw <= tce_pkg::HW_W'(cur_addr);
          end
          state <= S_RESULT;
        end

        S_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/text_console_engine.sv
// Top level of the text console engine: ports, register write decode, result register.
//
// Commands enter on the s_ channel (command in s_tuser, operands in s_tdata) and
// each produces exactly one result beat on the m_ channel carrying the cursor,
// the hardware cursor offset, the scroll count and, for read cell, the cell data.
// Registers are written through wr_en / wr_index / wr_data, one per cycle.
//
// Sequence: a plain character is accepted, written to memory with the cursor
// advanced, then the enabled hardware cursor follows and the result is presented;
// an in-range read cell reads memory and waits for the registered data, and a
// command that only moves the cursor skips the memory step. A tab writes spaces
// to the next tab stop. Every scroll walks the screen memory through its single
// read and write port: ROWS*COLS - COLS copy beats, a drain step and COLS blanks.
// Clear screen blanks all cells, clear to end of line or screen those from the cursor.
//
// After reset the engine blanks the whole screen, one cell a cycle, with
// s_tready low; register writes are taken meanwhile.
// The result sits in an output register, so a command is accepted while the
// previous result waits; if the receiver stalls, the next result holds in the
// engine and no further command is taken until the register drains.
module text_console_engine (
  input  logic        clk,
  input  logic        rst,

  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [3:0]  wr_data,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], column[14:8], row_index[19:15], zero pad
  input  logic [2:0]  s_tuser,   // command[2:0]

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // cursor_column[6:0], cursor_line[11:7], cursor_offset[22:12],
                                 // scroll_count[38:23], cell_value[54:39], zero pad
);

  tce_pkg::cfg_wr_t   cfg;
  tce_pkg::cmd_item_t item;
  tce_pkg::result_t   res;
  logic               res_valid;
  logic               res_ready;

  assign cfg.en    = wr_en;
  assign cfg.index = wr_index;
  assign cfg.data  = wr_data;

  assign item.cmd = s_tuser;
  assign item.ch  = s_tdata[7:0];
  assign item.x   = s_tdata[14:8];
  assign item.y   = s_tdata[19:15];

  tce_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (s_tvalid),
    .item       (item),
    .item_ready (s_tready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load a new beat when a result is ready and the slot is free or draining
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {1'b0, res};
    end
  end

endmodule
